@@ hdl/vfv_pkg.sv @@
// ============================================================================
// vfv_pkg - voxel face visibility package
// Shared types and codes for the voxel face visibility unit.
// ============================================================================
package vfv_pkg;

  localparam int CoordW   = 4;
  localparam int SectW    = 12;
  localparam int PosW     = 16;
  localparam int MaskW    = 6;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } vfv_action_e;

  typedef enum logic [1:0] {
    REG_SECTION_X = 2'd0,
    REG_SECTION_Y = 2'd1,
    REG_SECTION_Z = 2'd2
  } vfv_reg_e;

  // neighbour flags: bit0 +x, bit1 -x, bit2 +y, bit3 -y, bit4 +z, bit5 -z
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              cell_in;
    logic [MaskW-1:0]  nb_in;
  } vfv_info_t;

endpackage

@@ hdl/vfv_bank.sv @@
// ============================================================================
// vfv_bank - occupancy column bank
// One bank of column words, single-bit write port, two registered read ports.
// ============================================================================
module vfv_bank
  import vfv_pkg::*;
#(
  parameter int Depth = 32,
  parameter int WordW = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [(Depth>1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [(WordW>1 ? $clog2(WordW) : 1)-1:0] wbit_i,
  input  logic                             wdata_i,
  input  logic                             re_i,
  input  logic [(Depth>1 ? $clog2(Depth) : 1)-1:0] raddr_a_i,
  input  logic [(Depth>1 ? $clog2(Depth) : 1)-1:0] raddr_b_i,
  output logic [WordW-1:0]                 rdata_a_o,
  output logic [WordW-1:0]                 rdata_b_o
);

  logic [WordW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i][wbit_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

@@ hdl/vfv_face.sv @@
// ============================================================================
// vfv_face - face mask and position stage
// Picks the column words, forms the visible-face mask and the global
// position, and holds the result word until the sink takes it.
// ============================================================================
module vfv_face
  import vfv_pkg::*;
#(
  parameter int WordW          = 16,
  parameter int SECTION_SIDE   = 16,
  parameter int SECTION_HEIGHT = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  vfv_info_t                   info_i,
  input  logic [3:0][WordW-1:0]       rd_a_i,
  input  logic [3:0][WordW-1:0]       rd_b_i,
  input  logic [SectW-1:0]            section_x_i,
  input  logic [SectW-1:0]            section_y_i,
  input  logic [SectW-1:0]            section_z_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // face_mask[5:0], global_x[21:6], global_y[37:22], global_z[53:38], zero[55:54]
  output logic [55:0]                 m_axis_tdata_o
);

  function automatic logic bit_at(logic [WordW-1:0] w, logic [CoordW:0] i);
    logic [WordW-1:0] s;
    s = w >> i;
    return s[0];
  endfunction

  function automatic logic [PosW-1:0] gpos(logic [SectW-1:0] sect,
                                           logic [CoordW-1:0] c,
                                           logic [PosW-1:0] size);
    logic [PosW-1:0] prod;
    prod = {{(PosW-SectW){sect[SectW-1]}}, sect} * size;
    return prod + {{(PosW-CoordW){1'b0}}, c};
  endfunction

  localparam logic [PosW-1:0] SideW   = PosW'(SECTION_SIDE);
  localparam logic [PosW-1:0] HeightW = PosW'(SECTION_HEIGHT);

  logic             vld_q;
  logic [55:0]      data_q;
  logic [55:0]      data_d;
  logic             load;
  logic [1:0]       bc, bx, bz;
  logic [WordW-1:0] cw, xpw, xmw, zpw, zmw;
  logic [CoordW:0]  yi, yp, ym;
  logic             solid_c;
  logic [MaskW-1:0] mask;

  assign in_ready_o = !vld_q || m_axis_tready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    bc  = {info_i.x[0], info_i.z[0]};
    bx  = {~info_i.x[0], info_i.z[0]};
    bz  = {info_i.x[0], ~info_i.z[0]};
    cw  = rd_a_i[bc];
    xpw = rd_a_i[bx];
    xmw = rd_b_i[bx];
    zpw = rd_a_i[bz];
    zmw = rd_b_i[bz];
    yi  = {1'b0, info_i.y};
    yp  = yi + 5'd1;
    ym  = yi - 5'd1;
    solid_c = info_i.cell_in && bit_at(cw, yi);
    mask[0] = !(info_i.nb_in[0] && bit_at(xpw, yi));
    mask[1] = !(info_i.nb_in[1] && bit_at(xmw, yi));
    mask[2] = !(info_i.nb_in[2] && bit_at(cw, yp));
    mask[3] = !(info_i.nb_in[3] && bit_at(cw, ym));
    mask[4] = !(info_i.nb_in[4] && bit_at(zpw, yi));
    mask[5] = !(info_i.nb_in[5] && bit_at(zmw, yi));
    if (!solid_c) begin
      mask = '0;
    end
    data_d = {2'b00,
              gpos(section_z_i, info_i.z, SideW),
              gpos(section_y_i, info_i.y, HeightW),
              gpos(section_x_i, info_i.x, SideW),
              mask};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;

endmodule

@@ hdl/voxel_face_visibility_unit.sv @@
// ============================================================================
// voxel_face_visibility_unit - voxel face visibility top level
// Occupancy map in four column banks split by x and z parity; each query
// reads its own column and four neighbour columns in a single access.
// ============================================================================
// Query path: read stage (bank read, info_q), then face stage result register.
// Throughput: one word per cycle, writes and queries alike, unless the result
//   output stalls; the banked map gives each query its five columns in one read.
// Reset: section registers clear to 0, pipeline valids clear; the map is not
//   cleared and holds no valid state until written.
module voxel_face_visibility_unit
  import vfv_pkg::*;
#(
  parameter int SECTION_SIDE   = 16,
  parameter int SECTION_HEIGHT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // cell_x[3:0], cell_y[7:4], cell_z[11:8], solid[12], zero[15:13]
  input  logic [15:0]         s_axis_tdata,
  // action[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // face_mask[5:0], global_x[21:6], global_y[37:22], global_z[53:38], zero[55:54]
  output logic [55:0]         m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int XN    = SECTION_SIDE < 16 ? SECTION_SIDE : 16;
  localparam int YN    = SECTION_HEIGHT < 16 ? SECTION_HEIGHT : 16;
  localparam int HN    = (XN + 1) / 2;
  localparam int Depth = HN * HN;
  localparam int AW    = Depth > 1 ? $clog2(Depth) : 1;
  localparam int BW    = YN > 1 ? $clog2(YN) : 1;

  function automatic logic [AW-1:0] col_addr(logic [3:0] hx, logic [3:0] hz);
    return AW'(int'(hx) * HN + int'(hz));
  endfunction

  // configuration
  logic [SectW-1:0] sect_x_q, sect_y_q, sect_z_q;
  logic             cfg_we;
  vfv_reg_e         cfg_reg;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_reg = vfv_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sect_x_q <= '0;
      sect_y_q <= '0;
      sect_z_q <= '0;
    end else if (cfg_we) begin
      case (cfg_reg)
        REG_SECTION_X: sect_x_q <= pwdata[SectW-1:0];
        REG_SECTION_Y: sect_y_q <= pwdata[SectW-1:0];
        REG_SECTION_Z: sect_z_q <= pwdata[SectW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_SECTION_X: prdata = {{(CfgDataW-SectW){sect_x_q[SectW-1]}}, sect_x_q};
      REG_SECTION_Y: prdata = {{(CfgDataW-SectW){sect_y_q[SectW-1]}}, sect_y_q};
      REG_SECTION_Z: prdata = {{(CfgDataW-SectW){sect_z_q[SectW-1]}}, sect_z_q};
      default:       prdata = '0;
    endcase
  end

  // input decode
  logic [3:0]  cx, cy, cz;
  logic        csolid;
  vfv_action_e act;
  logic        acc, acc_q;
  logic [4:0]  xp, zp, yp;
  logic [3:0]  xm, zm;
  vfv_info_t   info_d, info_q;
  logic        s1_q;
  logic        face_ready;
  logic [AW-1:0] a_c, a_xp, a_xm, a_zp, a_zm;
  logic [3:0]            bank_we;
  logic [3:0][AW-1:0]    bank_ra, bank_rb;
  logic [3:0][YN-1:0]    rd_a, rd_b;

  assign cx     = s_axis_tdata[3:0];
  assign cy     = s_axis_tdata[7:4];
  assign cz     = s_axis_tdata[11:8];
  assign csolid = s_axis_tdata[12];
  assign act    = vfv_action_e'(s_axis_tuser);

  assign s_axis_tready = !s1_q || face_ready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign acc_q         = acc && (act == ACT_QUERY);

  always_comb begin
    xp = {1'b0, cx} + 5'd1;
    zp = {1'b0, cz} + 5'd1;
    yp = {1'b0, cy} + 5'd1;
    xm = cx - 4'd1;
    zm = cz - 4'd1;
    info_d.x        = cx;
    info_d.y        = cy;
    info_d.z        = cz;
    info_d.cell_in  = (32'(cx) < XN) && (32'(cy) < YN) && (32'(cz) < XN);
    info_d.nb_in[0] = 32'(xp) < XN;
    info_d.nb_in[1] = cx != 4'd0;
    info_d.nb_in[2] = 32'(yp) < YN;
    info_d.nb_in[3] = cy != 4'd0;
    info_d.nb_in[4] = 32'(zp) < XN;
    info_d.nb_in[5] = cz != 4'd0;
    a_c  = col_addr({1'b0, cx[3:1]}, {1'b0, cz[3:1]});
    a_xp = col_addr(xp[4:1], {1'b0, cz[3:1]});
    a_xm = col_addr({1'b0, xm[3:1]}, {1'b0, cz[3:1]});
    a_zp = col_addr({1'b0, cx[3:1]}, zp[4:1]);
    a_zm = col_addr({1'b0, cx[3:1]}, {1'b0, zm[3:1]});
  end

  // bank port steering
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bank_we[b] = 1'b0;
      bank_ra[b] = a_c;
      bank_rb[b] = a_c;
      if (2'(b) == {cx[0], cz[0]}) begin
        bank_we[b] = acc && (act == ACT_WRITE) && info_d.cell_in;
      end else if (2'(b) == {~cx[0], cz[0]}) begin
        bank_ra[b] = a_xp;
        bank_rb[b] = a_xm;
      end else if (2'(b) == {cx[0], ~cz[0]}) begin
        bank_ra[b] = a_zp;
        bank_rb[b] = a_zm;
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    vfv_bank #(
      .Depth (Depth),
      .WordW (YN)
    ) u_bank (
      .clk_i     (clk_i),
      .we_i      (bank_we[g]),
      .waddr_i   (a_c),
      .wbit_i    (cy[BW-1:0]),
      .wdata_i   (csolid),
      .re_i      (acc_q),
      .raddr_a_i (bank_ra[g]),
      .raddr_b_i (bank_rb[g]),
      .rdata_a_o (rd_a[g]),
      .rdata_b_o (rd_b[g])
    );
  end

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else if (acc_q) begin
      s1_q <= 1'b1;
    end else if (face_ready) begin
      s1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_q) begin
      info_q <= info_d;
    end
  end

  vfv_face #(
    .WordW          (YN),
    .SECTION_SIDE   (SECTION_SIDE),
    .SECTION_HEIGHT (SECTION_HEIGHT)
  ) u_face (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s1_q),
    .in_ready_o      (face_ready),
    .info_i          (info_q),
    .rd_a_i          (rd_a),
    .rd_b_i          (rd_b),
    .section_x_i     (sect_x_q),
    .section_y_i     (sect_y_q),
    .section_z_i     (sect_z_q),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  a_one_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bank_we))
    else $error("more than one bank written");

  a_outside_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !info_d.cell_in) |-> (bank_we == 4'b0000))
    else $error("write outside the section reached the map");

  a_query_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q |=> s1_q)
    else $error("accepted query lost before the face stage");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (act == ACT_WRITE) && !s1_q) |=> !s1_q)
    else $error("write word entered the query pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q && m_axis_tvalid && !m_axis_tready) |=> (s1_q && $stable(info_q)))
    else $error("stalled query changed in the read stage");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb - voxel face visibility unit testbench
// Fills two opposite corner blocks of the occupancy map, runs directed corner,
// buried and isolated cell cases, then random writes, queries and
// write-then-query clusters inside the corner blocks over several section
// offsets and idle/stall mixes. Every accepted query is predicted from a
// local copy of the map and the section registers, and each result word is
// checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import vfv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE   = 16;
  localparam int HEIGHT = 16;

  typedef struct packed {
    vfv_action_e       action;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] cz;
    logic              solid;
  } cell_op_t;

  typedef struct {
    logic [MaskW-1:0] mask;
    logic [PosW-1:0]  gx;
    logic [PosW-1:0]  gy;
    logic [PosW-1:0]  gz;
  } face_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [55:0]         m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [CfgAddrW-1:0] paddr         = '0;
  logic [CfgDataW-1:0] pwdata        = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  cell_op_t     cell_ops_q[$];
  face_result_t face_results_q[$];
  bit           occ_map [SIDE*HEIGHT*SIDE];
  logic signed [SectW-1:0] sect_x = '0;
  logic signed [SectW-1:0] sect_y = '0;
  logic signed [SectW-1:0] sect_z = '0;
  logic in_taken   = 1'b0;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   mismatches = 0;

  voxel_face_visibility_unit #(
    .SECTION_SIDE  (SIDE),
    .SECTION_HEIGHT(HEIGHT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatches += 1;
  endtask

  function automatic bit cell_solid(input int x, input int y, input int z);
    if (x < 0 || x >= SIDE || y < 0 || y >= HEIGHT || z < 0 || z >= SIDE)
      return 1'b0;
    return occ_map[(x * HEIGHT + y) * SIDE + z];
  endfunction

  function automatic face_result_t predict_faces(input cell_op_t op);
    face_result_t r;
    int x, y, z;
    x = op.cx;
    y = op.cy;
    z = op.cz;
    r.mask = '0;
    if (cell_solid(x, y, z)) begin
      r.mask[0] = !cell_solid(x + 1, y, z);
      r.mask[1] = !cell_solid(x - 1, y, z);
      r.mask[2] = !cell_solid(x, y + 1, z);
      r.mask[3] = !cell_solid(x, y - 1, z);
      r.mask[4] = !cell_solid(x, y, z + 1);
      r.mask[5] = !cell_solid(x, y, z - 1);
    end
    r.gx = 16'(x + int'(sect_x) * SIDE);
    r.gy = 16'(y + int'(sect_y) * HEIGHT);
    r.gz = 16'(z + int'(sect_z) * SIDE);
    return r;
  endfunction

  always @(negedge clk_i) begin
    cell_op_t op;
    if (!s_axis_tvalid || in_taken) begin
      if (cell_ops_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        op = cell_ops_q.pop_front();
        s_axis_tdata  <= {3'b000, op.solid, op.cz, op.cy, op.cx};
        s_axis_tuser  <= op.action;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    face_result_t got, want;
    cell_op_t     op;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.mask = m_axis_tdata[5:0];
        got.gx   = m_axis_tdata[21:6];
        got.gy   = m_axis_tdata[37:22];
        got.gz   = m_axis_tdata[53:38];
        if (face_results_q.size() == 0) begin
          report_mismatch("unexpected result word", got.gx, '0);
        end else begin
          want = face_results_q.pop_front();
          if (got.mask !== want.mask)
            report_mismatch("face_mask", 16'(got.mask), 16'(want.mask));
          if (got.gx !== want.gx) report_mismatch("global_x", got.gx, want.gx);
          if (got.gy !== want.gy) report_mismatch("global_y", got.gy, want.gy);
          if (got.gz !== want.gz) report_mismatch("global_z", got.gz, want.gz);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (vfv_reg_e'(paddr[3:2]))
          REG_SECTION_X: sect_x = pwdata[SectW-1:0];
          REG_SECTION_Y: sect_y = pwdata[SectW-1:0];
          REG_SECTION_Z: sect_z = pwdata[SectW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op.action = vfv_action_e'(s_axis_tuser);
        op.cx     = s_axis_tdata[3:0];
        op.cy     = s_axis_tdata[7:4];
        op.cz     = s_axis_tdata[11:8];
        op.solid  = s_axis_tdata[12];
        if (op.action == ACT_WRITE)
          occ_map[(int'(op.cx) * HEIGHT + int'(op.cy)) * SIDE + int'(op.cz)] = op.solid;
        else
          face_results_q.insert(face_results_q.size(), predict_faces(op));
      end
      in_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  function automatic void push_op(input vfv_action_e a, input int x, input int y,
                                  input int z, input logic s);
    cell_op_t op;
    op.action = a;
    op.cx     = 4'(x);
    op.cy     = 4'(y);
    op.cz     = 4'(z);
    op.solid  = s;
    cell_ops_q.insert(cell_ops_q.size(), op);
  endfunction

  task automatic apb_access(input logic wr, input vfv_reg_e idx,
                            input logic [CfgDataW-1:0] wdata,
                            output logic [CfgDataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_section(input int vx, input int vy, input int vz);
    logic [CfgDataW-1:0] rd;
    int vals [3];
    vals = '{vx, vy, vz};
    for (int i = 0; i < 3; i++)
      apb_access(1'b1, vfv_reg_e'(i), CfgDataW'(vals[i]), rd);
    for (int i = 0; i < 3; i++) begin
      apb_access(1'b0, vfv_reg_e'(i), '0, rd);
      if (rd[SectW-1:0] !== SectW'(vals[i]))
        report_mismatch("register readback", 16'(rd[SectW-1:0]), 16'(SectW'(vals[i])));
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (cell_ops_q.size() != 0 || s_axis_tvalid || face_results_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // cells stay in the three-wide part of a written corner block that lies at the map corner
  task automatic queue_random_ops(input int n);
    int cnt, kind, x, y, z, axis, nx, ny, nz, xlo, ylo;
    cnt = 0;
    while (cnt < n) begin
      xlo  = ($urandom_range(1) == 0) ? 0 : SIDE - 3;
      ylo  = (xlo == 0) ? 0 : HEIGHT - 3;
      x    = xlo + $urandom_range(2);
      y    = ylo + $urandom_range(2);
      z    = xlo + $urandom_range(2);
      kind = $urandom_range(3);
      if (kind == 0) begin
        push_op(ACT_QUERY, x, y, z, $urandom_range(1));
        cnt += 1;
      end else if (kind == 1) begin
        push_op(ACT_WRITE, x, y, z, $urandom_range(1));
        cnt += 1;
      end else begin
        axis = $urandom_range(5);
        nx   = x + (axis == 0) - (axis == 1);
        ny   = y + (axis == 2) - (axis == 3);
        nz   = z + (axis == 4) - (axis == 5);
        if (nx < xlo || nx > xlo + 2) nx = 2 * x - nx;
        if (ny < ylo || ny > ylo + 2) ny = 2 * y - ny;
        if (nz < xlo || nz > xlo + 2) nz = 2 * z - nz;
        push_op(ACT_WRITE, x, y, z, $urandom_range(3) != 0);
        push_op(ACT_WRITE, nx, ny, nz, $urandom_range(1));
        push_op(ACT_QUERY, x, y, z, $urandom_range(1));
        push_op(ACT_QUERY, nx, ny, nz, $urandom_range(1));
        cnt += 4;
      end
    end
  endtask

  initial begin
    int idle_tab  [4];
    int stall_tab [4];
    idle_tab  = '{0, 49, 0, 38};
    stall_tab = '{0, 0, 49, 38};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int b = 0; b < 2; b++)
      for (int x = 0; x < 4; x++)
        for (int y = 0; y < 4; y++)
          for (int z = 0; z < 4; z++)
            push_op(ACT_WRITE, b * (SIDE - 4) + x, b * (HEIGHT - 4) + y,
                    b * (SIDE - 4) + z, $urandom_range(1));

    // corner with empty neighbours, far corner with solid inner neighbours
    push_op(ACT_WRITE, 0, 0, 0, 1'b1);
    push_op(ACT_WRITE, 1, 0, 0, 1'b0);
    push_op(ACT_WRITE, 0, 1, 0, 1'b0);
    push_op(ACT_WRITE, 0, 0, 1, 1'b0);
    push_op(ACT_QUERY, 0, 0, 0, 1'b0);
    push_op(ACT_WRITE, 15, 15, 15, 1'b1);
    push_op(ACT_WRITE, 14, 15, 15, 1'b1);
    push_op(ACT_WRITE, 15, 14, 15, 1'b1);
    push_op(ACT_WRITE, 15, 15, 14, 1'b1);
    push_op(ACT_QUERY, 15, 15, 15, 1'b1);
    // isolated cell, then buried, then emptied
    push_op(ACT_WRITE, 8, 8, 8, 1'b1);
    push_op(ACT_WRITE, 9, 8, 8, 1'b0);
    push_op(ACT_WRITE, 7, 8, 8, 1'b0);
    push_op(ACT_WRITE, 8, 9, 8, 1'b0);
    push_op(ACT_WRITE, 8, 7, 8, 1'b0);
    push_op(ACT_WRITE, 8, 8, 9, 1'b0);
    push_op(ACT_WRITE, 8, 8, 7, 1'b0);
    push_op(ACT_QUERY, 8, 8, 8, 1'b0);
    push_op(ACT_WRITE, 9, 8, 8, 1'b1);
    push_op(ACT_WRITE, 7, 8, 8, 1'b1);
    push_op(ACT_WRITE, 8, 9, 8, 1'b1);
    push_op(ACT_WRITE, 8, 7, 8, 1'b1);
    push_op(ACT_WRITE, 8, 8, 9, 1'b1);
    push_op(ACT_WRITE, 8, 8, 7, 1'b1);
    push_op(ACT_QUERY, 8, 8, 8, 1'b0);
    push_op(ACT_WRITE, 8, 8, 8, 1'b0);
    push_op(ACT_QUERY, 8, 8, 8, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      case (p)
        0: set_section(-2048, 2047, 0);
        1: set_section(2047, -2048, -1);
        2: set_section($urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                       $urandom_range(4095) - 2048);
        default: set_section(-1, 1, 2047);
      endcase
      queue_random_ops(75);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
